@@ hdl/htfd_pkg.sv @@
package htfd_pkg;

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  // Byte positions within one six-byte reply frame.
  localparam logic [2:0] POS_TEMP_HI  = 3'd0;
  localparam logic [2:0] POS_TEMP_LO  = 3'd1;
  localparam logic [2:0] POS_TEMP_CRC = 3'd2;
  localparam logic [2:0] POS_HUM_HI   = 3'd3;
  localparam logic [2:0] POS_HUM_LO   = 3'd4;
  localparam logic [2:0] POS_HUM_CRC  = 3'd5;

  // Conversion scale factors, in hundredths.
  localparam logic [14:0] TEMP_SPAN   = 15'd17500;
  localparam logic [14:0] TEMP_OFFSET = 15'd4500;
  localparam logic [14:0] HUM_SPAN    = 15'd10000;

  typedef struct packed {
    logic [15:0] temp_word;
    logic [15:0] hum_word;
    logic        temp_ok;
    logic        hum_ok;
    logic        updated;
  } frame_result_t;

  // CRC-8 update for one byte, MSB first.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  // Floor of x / 65535 for x below 2^31. With q0 = x >> 16 the remainder
  // estimate is x[15:0] + q0, which stays below twice the divisor, so one
  // compare corrects the quotient.
  function automatic logic [14:0] div_by_65535(input logic [30:0] x);
    logic [14:0] q0;
    logic [16:0] r0;
    q0 = x[30:16];
    r0 = {1'b0, x[15:0]} + {2'b00, q0};
    if (r0 >= 17'd65535) begin
      return q0 + 15'd1;
    end
    return q0;
  endfunction

endpackage

@@ hdl/humidity_temp_frame_decoder_unit.sv @@
// The sixth byte of a frame yields its result via the input, result and output registers.
// Throughput: one byte item per cycle barring output stalls; bytes 0 to 4 give no result.
// The rate is set by the CRC-8 byte update, which is combinational.
// Reset (rst, synchronous, active high) empties all stages, sets the byte position to 0,
// the CRC to 0xFF, and clears the stored words, so early bad-CRC results read -4500 and 0.
module humidity_temp_frame_decoder_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         data_byte,
  input  logic               frame_start,
  input  logic               in_valid,
  output logic               in_ready,
  output logic signed [14:0] temperature_centi,
  output logic [13:0]        humidity_centi,
  output logic [15:0]        raw_temperature,
  output logic [15:0]        raw_humidity,
  output logic               temp_crc_ok,
  output logic               hum_crc_ok,
  output logic               updated,
  output logic               out_valid,
  input  logic               out_ready
);

  // The parser holds each accepted byte in an input register and, when the
  // following stage can take it, runs the CRC and frame bookkeeping on it.
  // Only the humidity CRC byte (the last of a frame) produces a result, which
  // carries the raw words to report and the CRC flags of the frame.
  htfd_pkg::frame_result_t res;
  logic                    res_valid;
  logic                    res_ready;

  htfd_frame_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .data_byte   (data_byte),
    .frame_start (frame_start),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  // The scaler turns the raw words into hundredths of a degree and of a
  // percent with one constant multiply per word and a divide by 65535 done as a
  // shift plus a single correction, and holds the result for the consumer.
  // Ready propagates backward through both stages, so a stalled output still
  // lets the input register and the parser fill before input stalls.
  htfd_scaler u_scaler (
    .clk               (clk),
    .rst               (rst),
    .res_valid         (res_valid),
    .res_ready         (res_ready),
    .res               (res),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .temperature_centi (temperature_centi),
    .humidity_centi    (humidity_centi),
    .raw_temperature   (raw_temperature),
    .raw_humidity      (raw_humidity),
    .temp_crc_ok       (temp_crc_ok),
    .hum_crc_ok        (hum_crc_ok),
    .updated           (updated)
  );

endmodule

@@ hdl/htfd_frame_parser.sv @@
module htfd_frame_parser (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [7:0]             data_byte,
  input  logic                   frame_start,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   res_valid,
  input  logic                   res_ready,
  output htfd_pkg::frame_result_t res
);

  logic        item_valid;
  logic [7:0]  item_byte;
  logic        item_start;

  logic [2:0]  byte_position;
  logic [7:0]  crc_accum;
  logic [7:0]  high_byte;
  logic [15:0] pending_temp_word;
  logic [15:0] pending_hum_word;
  logic        pending_temp_ok;
  logic [15:0] good_temp_word;
  logic [15:0] good_hum_word;

  logic        advance;
  logic        fire;
  logic [2:0]  pos;
  logic [7:0]  crc_seed;
  logic [7:0]  crc_next;
  logic        hum_ok;
  logic        upd;

  assign advance  = !res_valid || res_ready;
  assign fire     = item_valid && advance;
  assign in_ready = !item_valid || advance;

  assign pos = item_start ? htfd_pkg::POS_TEMP_HI : byte_position;

  assign crc_seed = (pos == htfd_pkg::POS_TEMP_HI || pos == htfd_pkg::POS_HUM_HI) ?
                    htfd_pkg::CRC_INIT : crc_accum;
  assign crc_next = htfd_pkg::crc8_byte(crc_seed, item_byte);
  assign hum_ok   = (crc_accum == item_byte);
  assign upd      = pending_temp_ok && hum_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      item_byte  <= data_byte;
      item_start <= frame_start;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid         <= 1'b0;
      byte_position     <= htfd_pkg::POS_TEMP_HI;
      crc_accum         <= htfd_pkg::CRC_INIT;
      high_byte         <= 8'd0;
      pending_temp_word <= 16'd0;
      pending_hum_word  <= 16'd0;
      pending_temp_ok   <= 1'b0;
      good_temp_word    <= 16'd0;
      good_hum_word     <= 16'd0;
    end else begin
      if (advance) begin
        res_valid <= 1'b0;
      end
      if (fire) begin
        byte_position <= (pos >= htfd_pkg::POS_HUM_CRC) ? htfd_pkg::POS_TEMP_HI : pos + 3'd1;
        unique case (pos) inside
          htfd_pkg::POS_TEMP_HI, htfd_pkg::POS_HUM_HI: begin
            crc_accum <= crc_next;
            high_byte <= item_byte;
          end
          htfd_pkg::POS_TEMP_LO: begin
            crc_accum         <= crc_next;
            pending_temp_word <= {high_byte, item_byte};
          end
          htfd_pkg::POS_TEMP_CRC: begin
            pending_temp_ok <= (crc_accum == item_byte);
            crc_accum       <= htfd_pkg::CRC_INIT;
          end
          htfd_pkg::POS_HUM_LO: begin
            crc_accum        <= crc_next;
            pending_hum_word <= {high_byte, item_byte};
          end
          default: begin
            crc_accum     <= htfd_pkg::CRC_INIT;
            res_valid     <= 1'b1;
            res.temp_ok   <= pending_temp_ok;
            res.hum_ok    <= hum_ok;
            res.updated   <= upd;
            if (upd) begin
              good_temp_word <= pending_temp_word;
              good_hum_word  <= pending_hum_word;
              res.temp_word  <= pending_temp_word;
              res.hum_word   <= pending_hum_word;
            end else begin
              res.temp_word  <= good_temp_word;
              res.hum_word   <= good_hum_word;
            end
          end
        endcase
      end
    end
  end

endmodule

@@ hdl/htfd_scaler.sv @@
module htfd_scaler (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   res_valid,
  output logic                   res_ready,
  input  htfd_pkg::frame_result_t res,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [14:0]     temperature_centi,
  output logic [13:0]            humidity_centi,
  output logic [15:0]            raw_temperature,
  output logic [15:0]            raw_humidity,
  output logic                   temp_crc_ok,
  output logic                   hum_crc_ok,
  output logic                   updated
);

  logic [30:0] temp_prod;
  logic [30:0] hum_prod;
  logic [14:0] temp_q;
  logic [14:0] hum_q;

  assign res_ready = !out_valid || out_ready;

  assign temp_prod = 31'(htfd_pkg::TEMP_SPAN) * 31'(res.temp_word);
  assign hum_prod  = 31'(htfd_pkg::HUM_SPAN) * 31'(res.hum_word);
  assign temp_q    = htfd_pkg::div_by_65535(temp_prod);
  assign hum_q     = htfd_pkg::div_by_65535(hum_prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
    if (res_ready && res_valid) begin
      temperature_centi <= $signed(temp_q - htfd_pkg::TEMP_OFFSET);
      humidity_centi    <= hum_q[13:0];
      raw_temperature   <= res.temp_word;
      raw_humidity      <= res.hum_word;
      temp_crc_ok       <= res.temp_ok;
      hum_crc_ok        <= res.hum_ok;
      updated           <= res.updated;
    end
  end

endmodule

@@ test/humidity_temp_frame_decoder_unit_test.sv @@
`timescale 1ns / 100ps

module humidity_temp_frame_decoder_unit_test;

  // Roughly how many random bytes follow the directed frames.
  localparam int RANDOM_ITEMS = 1850;

  // One byte item as the sender will offer it. When hold_for_drain is set the
  // sender waits until every expected reading has arrived before offering it.
  typedef struct {
    logic [7:0] value;
    logic       start;
    logic       hold_for_drain;
  } reply_byte_t;

  // One decoded reading as the block should report it.
  typedef struct {
    logic signed [14:0] temp_centi;
    logic [13:0]        hum_centi;
    logic [15:0]        temp_word;
    logic [15:0]        hum_word;
    logic               temp_ok;
    logic               hum_ok;
    logic               fresh;
  } reading_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic [7:0]         data_byte = 8'h00;
  logic               frame_start = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [14:0] temperature_centi;
  logic [13:0]        humidity_centi;
  logic [15:0]        raw_temperature;
  logic [15:0]        raw_humidity;
  logic               temp_crc_ok;
  logic               hum_crc_ok;
  logic               updated;
  logic               out_valid;
  logic               out_ready = 1'b0;

  humidity_temp_frame_decoder_unit uut (
    .clk               (clk),
    .rst               (rst),
    .data_byte         (data_byte),
    .frame_start       (frame_start),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .temperature_centi (temperature_centi),
    .humidity_centi    (humidity_centi),
    .raw_temperature   (raw_temperature),
    .raw_humidity      (raw_humidity),
    .temp_crc_ok       (temp_crc_ok),
    .hum_crc_ok        (hum_crc_ok),
    .updated           (updated),
    .out_valid         (out_valid),
    .out_ready         (out_ready)
  );

  // Bytes still to be offered, and readings predicted but not yet seen.
  reply_byte_t reply_queue[$];
  reading_t    reading_expect[$];

  int error_count = 0;
  int sent_count = 0;
  int total_items = 0;

  // When set, the receiver refuses every reading so that the block backs up.
  logic long_stall = 1'b0;

  // Decoder state as the predictor tracks it.
  logic [2:0]  frame_pos = htfd_pkg::POS_TEMP_HI;
  logic [7:0]  crc_run = htfd_pkg::CRC_INIT;
  logic [7:0]  hi_byte = 8'h00;
  logic [15:0] temp_pending = 16'h0000;
  logic [15:0] hum_pending = 16'h0000;
  logic        temp_pending_ok = 1'b0;
  logic [15:0] stored_temp = 16'h0000;
  logic [15:0] stored_hum = 16'h0000;

  int   send_gap = 0;
  logic send_idle_on = 1'b1;
  int   recv_gap = 0;
  logic recv_idle_on = 1'b1;

  always #5 clk = ~clk;

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
  end

  // CRC-8 over one byte, MSB first, written as a bit-serial shift register:
  // each incoming bit is compared with the top bit, and a mismatch folds in
  // the polynomial after the shift.
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] acc;
    logic       fb;
    acc = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = acc[7] ^ b[i];
      acc = {acc[6:0], 1'b0} ^ (fb ? htfd_pkg::CRC_POLY : 8'h00);
    end
    return acc;
  endfunction

  function automatic logic [7:0] word_crc(input logic [15:0] w);
    return crc8_step(crc8_step(htfd_pkg::CRC_INIT, w[15:8]), w[7:0]);
  endfunction

  // Advances the predicted decoder by one accepted byte. The sixth byte of a
  // frame produces one reading; the other five only move the state along.
  task automatic predict_frame_byte(input logic [7:0] b, input logic start);
    logic [2:0] pos;
    logic       hum_ok;
    int         t_hund;
    int         h_hund;
    reading_t   r;
    pos = start ? htfd_pkg::POS_TEMP_HI : frame_pos;
    case (pos)
      htfd_pkg::POS_TEMP_HI, htfd_pkg::POS_HUM_HI: begin
        // Each word's CRC starts over from the initial value.
        crc_run = crc8_step(htfd_pkg::CRC_INIT, b);
        hi_byte = b;
      end
      htfd_pkg::POS_TEMP_LO: begin
        crc_run = crc8_step(crc_run, b);
        temp_pending = {hi_byte, b};
      end
      htfd_pkg::POS_TEMP_CRC: begin
        temp_pending_ok = (crc_run == b);
        crc_run = htfd_pkg::CRC_INIT;
      end
      htfd_pkg::POS_HUM_LO: begin
        crc_run = crc8_step(crc_run, b);
        hum_pending = {hi_byte, b};
      end
      default: begin
        hum_ok = (crc_run == b);
        crc_run = htfd_pkg::CRC_INIT;
        // Only a frame with both checks passing replaces the stored words;
        // otherwise the last good words are repeated.
        if (temp_pending_ok && hum_ok) begin
          stored_temp = temp_pending;
          stored_hum = hum_pending;
        end
        t_hund = (17500 * int'(stored_temp)) / 65535;
        h_hund = (10000 * int'(stored_hum)) / 65535;
        r.temp_centi = 15'(t_hund - 4500);
        r.hum_centi = 14'(h_hund);
        r.temp_word = stored_temp;
        r.hum_word = stored_hum;
        r.temp_ok = temp_pending_ok;
        r.hum_ok = hum_ok;
        r.fresh = temp_pending_ok && hum_ok;
        reading_expect.push_back(r);
      end
    endcase
    frame_pos = (pos >= htfd_pkg::POS_HUM_CRC) ? htfd_pkg::POS_TEMP_HI : pos + 3'd1;
  endtask

  task automatic report_field(input string field, input int exp_val, input int act_val);
    error_count++;
    if (error_count <= 10) begin
      $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, field, exp_val, act_val);
    end
  endtask

  task automatic push_item(input logic [7:0] value, input logic start, input logic drain);
    reply_byte_t it;
    it.value = value;
    it.start = start;
    it.hold_for_drain = drain;
    reply_queue.push_back(it);
  endtask

  // Queues one six-byte reply. A failing CRC is made by flipping at least one
  // bit of the correct check byte.
  task automatic push_frame(input logic [15:0] tw, input logic [15:0] hw, input logic start,
                            input logic t_good, input logic h_good, input logic drain);
    logic [7:0] t_crc;
    logic [7:0] h_crc;
    t_crc = word_crc(tw) ^ (t_good ? 8'h00 : 8'($urandom_range(1, 255)));
    h_crc = word_crc(hw) ^ (h_good ? 8'h00 : 8'($urandom_range(1, 255)));
    push_item(tw[15:8], start, drain);
    push_item(tw[7:0], 1'b0, 1'b0);
    push_item(t_crc, 1'b0, 1'b0);
    push_item(hw[15:8], 1'b0, 1'b0);
    push_item(hw[7:0], 1'b0, 1'b0);
    push_item(h_crc, 1'b0, 1'b0);
  endtask

  // Words lean toward the two extremes so that both ends of the scale recur.
  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Stimulus, then the end-of-run check.
  initial begin
    int  kind;
    int  len;
    bit  drained;
    drained = 0;

    // Directed part. Both extremes of the word range with correct CRCs, the
    // second frame relying on the position wrapping with no frame_start.
    push_frame(16'h0000, 16'h0000, 1'b1, 1'b1, 1'b1, 1'b0);
    push_frame(16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 1'b1, 1'b0);
    // A partial frame that the next frame_start cuts off without a reading.
    push_item(8'hA5, 1'b1, 1'b0);
    push_item(8'h5A, 1'b0, 1'b0);
    // Temperature CRC wrong, then humidity CRC wrong: both keep the stored
    // words. The last frame also waits for all readings to drain first.
    push_frame(16'h1234, 16'h5678, 1'b1, 1'b0, 1'b1, 1'b0);
    push_frame(16'h8001, 16'h7FFE, 1'b0, 1'b1, 1'b0, 1'b1);

    // Random part: mostly well-formed replies with random words and mostly
    // good CRCs, mixed with cut-off frames and loose noise bytes.
    len = reply_queue.size() + RANDOM_ITEMS;
    while (reply_queue.size() < len) begin
      kind = $urandom_range(0, 99);
      if (kind < 72) begin
        push_frame(pick_word(), pick_word(), $urandom_range(0, 4) != 0,
                   $urandom_range(0, 6) != 0, $urandom_range(0, 6) != 0,
                   !drained && reply_queue.size() > 1000);
        if (reply_queue.size() > 1006) begin
          drained = 1;
        end
      end else if (kind < 86) begin
        for (int i = 0; i < $urandom_range(1, 5); i++) begin
          push_item(8'($urandom_range(0, 255)), i == 0, 1'b0);
        end
      end else begin
        for (int i = 0; i < $urandom_range(1, 8); i++) begin
          push_item(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0, 1'b0);
        end
      end
    end
    total_items = reply_queue.size();

    wait (sent_count == total_items);
    wait (reading_expect.size() == 0);
    // Allow for the block's registers plus a receiver stall, so that any
    // stray reading would still show up.
    repeat (40) @(posedge clk);
    if (error_count == 0 && reading_expect.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Once the run is under way, hold the receiver off long enough for the
  // block to fill and drop in_ready while the sender keeps offering bytes.
  initial begin
    wait (!rst && sent_count >= 600);
    @(posedge clk);
    long_stall <= 1'b1;
    repeat (400) @(posedge clk);
    long_stall <= 1'b0;
  end

  // Byte sender. The prediction is made here, at the edge where the item is
  // accepted. After each accepted item a gap of idle cycles is drawn; for
  // stretches of the run the gaps are switched off entirely.
  always @(posedge clk) begin : reply_sender
    logic        offering;
    reply_byte_t nxt;
    offering = in_valid;
    if (rst) begin
      offering = 1'b0;
      send_gap = 0;
      send_idle_on = 1'b1;
    end else begin
      if (in_valid && in_ready) begin
        predict_frame_byte(data_byte, frame_start);
        sent_count++;
        offering = 1'b0;
        if ($urandom_range(0, 99) == 0) begin
          send_idle_on = !send_idle_on;
        end
        // During the long receiver stall the sender pushes as hard as it can.
        send_gap = (send_idle_on && !long_stall) ? $urandom_range(0, 16) : 0;
      end
      if (!offering) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (reply_queue.size() != 0 &&
                     !(reply_queue[0].hold_for_drain && reading_expect.size() != 0)) begin
          nxt = reply_queue.pop_front();
          data_byte <= nxt.value;
          frame_start <= nxt.start;
          offering = 1'b1;
        end
      end
    end
    in_valid <= offering;
  end

  // Reading receiver and checker. Every accepted reading is matched against
  // the oldest prediction, one field at a time.
  always @(posedge clk) begin : reading_checker
    logic     taking;
    reading_t e;
    taking = out_ready;
    if (rst) begin
      taking = 1'b0;
      recv_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (reading_expect.size() == 0) begin
          error_count++;
          if (error_count <= 10) begin
            $display("%0t: reading arrived with none expected", $realtime);
          end
        end else begin
          e = reading_expect.pop_front();
          if (temperature_centi !== e.temp_centi) begin
            report_field("temperature_centi", int'(e.temp_centi), int'(temperature_centi));
          end
          if (humidity_centi !== e.hum_centi) begin
            report_field("humidity_centi", int'(e.hum_centi), int'(humidity_centi));
          end
          if (raw_temperature !== e.temp_word) begin
            report_field("raw_temperature", int'(e.temp_word), int'(raw_temperature));
          end
          if (raw_humidity !== e.hum_word) begin
            report_field("raw_humidity", int'(e.hum_word), int'(raw_humidity));
          end
          if (temp_crc_ok !== e.temp_ok) begin
            report_field("temp_crc_ok", int'(e.temp_ok), int'(temp_crc_ok));
          end
          if (hum_crc_ok !== e.hum_ok) begin
            report_field("hum_crc_ok", int'(e.hum_ok), int'(hum_crc_ok));
          end
          if (updated !== e.fresh) begin
            report_field("updated", int'(e.fresh), int'(updated));
          end
        end
        if ($urandom_range(0, 29) == 0) begin
          recv_idle_on = !recv_idle_on;
        end
        recv_gap = recv_idle_on ? $urandom_range(0, 16) : 0;
        taking = 1'b0;
      end
      if (long_stall) begin
        taking = 1'b0;
      end else if (!taking) begin
        if (recv_gap != 0) begin
          recv_gap--;
        end else begin
          taking = 1'b1;
        end
      end
    end
    out_ready <= taking;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ humidity_temp_frame_decoder_unit.f @@
hdl/htfd_pkg.sv
hdl/htfd_frame_parser.sv
hdl/htfd_scaler.sv
hdl/humidity_temp_frame_decoder_unit.sv
test/humidity_temp_frame_decoder_unit_test.sv
